// ===== rtl/radio_api_tx_frame_sequencer_macros.svh =====
// assertion macros used by rtfs_core in the frame sequencer rtl
`ifndef RADIO_API_TX_FRAME_SEQUENCER_MACROS_SVH
`define RADIO_API_TX_FRAME_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RTFS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RTFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rtfs_pkg.sv =====
// types and constants of the radio api transmit frame sequencer
package rtfs_pkg;

   // payload bytes carried in each frame
   localparam int unsigned PAYLOAD_BYTES = 2;

   // fixed frame bytes
   localparam logic [7:0] DELIM_BYTE    = 8'h7E;
   localparam logic [7:0] LEN_HI_BYTE   = 8'h00;
   localparam logic [7:0] LEN_LO_BYTE   = 8'(5 + PAYLOAD_BYTES);
   localparam logic [7:0] API_ID_BYTE   = 8'h01;
   localparam logic [7:0] FRAME_ID_BYTE = 8'h01;
   localparam logic [7:0] OPTIONS_BYTE  = 8'h00;
   localparam logic [7:0] CHECK_BASE    = 8'hFF;
   localparam logic [1:0] PAYLOAD_LEFT_INIT = 2'(PAYLOAD_BYTES & 3);

   // event codes
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_COACH   = 3'd1,
      OP_CANTX   = 3'd2,
      OP_TAGOUT  = 3'd3,
      OP_TIMEOUT = 3'd4
   } op_type;

   // top modes
   typedef enum logic [1:0] {
      MODE_SLEEP  = 2'd0,
      MODE_RESP   = 2'd1,
      MODE_STATUS = 2'd2
   } mode_type;

   // frame byte steps
   typedef enum logic [3:0] {
      STEP_DELIM   = 4'd0,
      STEP_LEN_HI  = 4'd1,
      STEP_LEN_LO  = 4'd2,
      STEP_API     = 4'd3,
      STEP_FRAMEID = 4'd4,
      STEP_ADDR_HI = 4'd5,
      STEP_ADDR_LO = 4'd6,
      STEP_OPTIONS = 4'd7,
      STEP_DATA    = 4'd8,
      STEP_CHECK   = 4'd9
   } step_type;

   // csr register indexes
   typedef enum logic [0:0] {
      CSR_DEST_ADDRESS = 1'b0,
      CSR_PAYLOAD_WORD = 1'b1
   } csr_index_type;

   // one event beat
   typedef struct packed {
      logic [2:0] op;
      logic       paired;
      logic       tx_ready;
   } req_payload_type;

   // one result beat
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] tx_byte;
      logic       frame_done;
      logic [1:0] mode;
   } rsp_payload_type;

endpackage

// ===== rtl/rtfs_if.sv =====
// valid/ready channel interfaces for event and result beats
interface rtfs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic       paired;
   logic       tx_ready;

   modport source (output valid, output op, output paired, output tx_ready, input ready);
   modport sink   (input valid, input op, input paired, input tx_ready, output ready);
endinterface

interface rtfs_rsp_if;
   logic       valid;
   logic       ready;
   logic       byte_valid;
   logic [7:0] tx_byte;
   logic       frame_done;
   logic [1:0] mode;

   modport source (output valid, output byte_valid, output tx_byte, output frame_done,
                   output mode, input ready);
   modport sink   (input valid, input byte_valid, input tx_byte, input frame_done,
                   input mode, output ready);
endinterface

// ===== rtl/rtfs_core.sv =====
// mode and frame state, csr registers and the per-event step logic
`include "radio_api_tx_frame_sequencer_macros.svh"

module rtfs_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [0:0]               csr_index,
   input  logic [15:0]              csr_wdata,
   input  logic                     step_en,
   input  rtfs_pkg::req_payload_type step_req,
   output rtfs_pkg::rsp_payload_type step_rsp
);
   import rtfs_pkg::*;

   logic [15:0] dest_address_ff;
   logic [15:0] payload_word_ff;
   mode_type    mode_ff,    mode_in;
   step_type    step_ff,    step_in;
   logic [7:0]  sum_ff,     sum_in;
   logic [1:0]  left_ff,    left_in;
   logic        pidx_ff,    pidx_in;
   logic        aidx_ff,    aidx_in;
   logic        pending_ff, pending_in;

   logic        is_tick;
   logic        known_op;
   logic        pending_set;
   logic        send;
   logic        done;
   logic [7:0]  tx_byte;
   logic [7:0]  addr_byte;
   logic [7:0]  payload_byte;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_address_ff <= '0;
         payload_word_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST_ADDRESS: dest_address_ff <= csr_wdata;
            CSR_PAYLOAD_WORD: payload_word_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign addr_byte    = aidx_ff ? dest_address_ff[7:0] : dest_address_ff[15:8];
   assign payload_byte = pidx_ff ? payload_word_ff[7:0] : payload_word_ff[15:8];

   assign is_tick     = (step_req.op == OP_TICK);
   assign known_op    = (step_req.op <= OP_TIMEOUT);
   assign pending_set = pending_ff | is_tick;

   // mode transitions and send decision
   always_comb begin
      mode_in = mode_ff;
      send    = 1'b0;
      if (pending_set && known_op) begin
         unique case (mode_ff)
            MODE_SLEEP: begin
               if (step_req.op == OP_COACH) begin
                  mode_in = MODE_RESP;
               end else if (step_req.op == OP_CANTX) begin
                  mode_in = MODE_STATUS;
               end
            end
            MODE_RESP: begin
               if (is_tick) begin
                  send = 1'b1;
                  if (step_req.paired) begin
                     mode_in = MODE_STATUS;
                  end
               end
            end
            MODE_STATUS: begin
               if (step_req.op == OP_TAGOUT || step_req.op == OP_TIMEOUT) begin
                  mode_in = MODE_SLEEP;
               end else if (is_tick && step_req.tx_ready) begin
                  send = 1'b1;
               end
            end
            default: mode_in = MODE_SLEEP;
         endcase
      end
   end

   // frame byte selection and step advance
   always_comb begin
      step_in    = step_ff;
      sum_in     = sum_ff;
      left_in    = left_ff;
      pidx_in    = pidx_ff;
      aidx_in    = aidx_ff;
      pending_in = pending_set;
      done       = 1'b0;
      tx_byte    = 8'h00;
      if (send) begin
         unique case (step_ff)
            STEP_LEN_HI: begin
               tx_byte = LEN_HI_BYTE;
               step_in = STEP_LEN_LO;
            end
            STEP_LEN_LO: begin
               tx_byte = LEN_LO_BYTE;
               left_in = PAYLOAD_LEFT_INIT;
               step_in = STEP_API;
            end
            STEP_API: begin
               tx_byte = API_ID_BYTE;
               sum_in  = sum_ff + API_ID_BYTE;
               step_in = STEP_FRAMEID;
            end
            STEP_FRAMEID: begin
               tx_byte = FRAME_ID_BYTE;
               sum_in  = sum_ff + FRAME_ID_BYTE;
               step_in = STEP_ADDR_HI;
            end
            STEP_ADDR_HI: begin
               tx_byte = addr_byte;
               sum_in  = sum_ff + addr_byte;
               aidx_in = ~aidx_ff;
               step_in = STEP_ADDR_LO;
            end
            STEP_ADDR_LO: begin
               tx_byte = addr_byte;
               sum_in  = sum_ff + addr_byte;
               step_in = STEP_OPTIONS;
            end
            STEP_OPTIONS: begin
               tx_byte = OPTIONS_BYTE;
               step_in = STEP_DATA;
            end
            STEP_DATA: begin
               tx_byte = payload_byte;
               sum_in  = sum_ff + payload_byte;
               pidx_in = ~pidx_ff;
               if (left_ff > 2'd1) begin
                  left_in = left_ff - 2'd1;
               end else begin
                  left_in = 2'd0;
                  step_in = STEP_CHECK;
               end
            end
            STEP_CHECK: begin
               tx_byte    = CHECK_BASE - sum_ff;
               step_in    = STEP_DELIM;
               pending_in = 1'b0;
               sum_in     = 8'h00;
               pidx_in    = 1'b0;
               aidx_in    = 1'b0;
               done       = 1'b1;
            end
            // delimiter, and any step code outside the frame
            default: begin
               tx_byte = DELIM_BYTE;
               step_in = STEP_LEN_HI;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SLEEP;
         step_ff    <= STEP_DELIM;
         sum_ff     <= '0;
         left_ff    <= '0;
         pidx_ff    <= 1'b0;
         aidx_ff    <= 1'b0;
         pending_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff    <= mode_in;
         step_ff    <= step_in;
         sum_ff     <= sum_in;
         left_ff    <= left_in;
         pidx_ff    <= pidx_in;
         aidx_ff    <= aidx_in;
         pending_ff <= pending_in;
      end
   end

   assign step_rsp.byte_valid = send;
   assign step_rsp.tx_byte    = tx_byte;
   assign step_rsp.frame_done = done;
   assign step_rsp.mode       = mode_in;

   // checks
   `RTFS_ASSERT_IMPLIES(a_done_needs_send, clock, reset, done, send,
                        "frame_done without a sent byte")
   `RTFS_ASSERT_IMPLIES(a_idle_byte_zero, clock, reset, !send, tx_byte == 8'h00,
                        "nonzero byte while nothing is sent")
   `RTFS_ASSERT_NEXT(a_frame_restart, clock, reset, step_en && done,
                     step_ff == STEP_DELIM && sum_ff == 8'h00 && !pending_ff,
                     "frame state not cleared after checksum")
   `RTFS_ASSERT_NEXT(a_tick_pending, clock, reset, step_en && send && !done,
                     pending_ff, "pending flag lost mid-frame")
endmodule

// ===== rtl/radio_api_tx_frame_sequencer.sv =====
// Radio API transmit frame sequencer. Takes one event beat per cycle on req_chan, unless the
// result side stalls, and returns exactly one result beat per event on rsp_chan. The beat goes
// through an input register, the step logic in rtfs_core (mode update, frame byte choice,
// checksum add) and a result register; the single mode and frame state update in rtfs_core
// is the only loop, so the sustained rate is one event per clock without stalls. A waiting
// result holds its register while the next event is taken into the input register. The user
// must write registers dest_address (index 0) and payload_word (index 1) on the csr port only
// while the block is idle; the block itself does not enforce this.
module radio_api_tx_frame_sequencer (
   input  logic        clock,
   input  logic        reset,
   rtfs_req_if.sink    req_chan,
   rtfs_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import rtfs_pkg::*;

   logic            in_valid_ff,  in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type step_rsp;
   req_payload_type req_beat;
   logic            advance;

   // input beat moves on when the result register is free or being drained
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign req_beat.op       = req_chan.op;
   assign req_beat.paired   = req_chan.paired;
   assign req_beat.tx_ready = req_chan.tx_ready;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_beat;
      end
   end

   rtfs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_en   (advance),
      .step_req  (in_data_ff),
      .step_rsp  (step_rsp)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.byte_valid = out_data_ff.byte_valid;
   assign rsp_chan.tx_byte    = out_data_ff.tx_byte;
   assign rsp_chan.frame_done = out_data_ff.frame_done;
   assign rsp_chan.mode       = out_data_ff.mode;
endmodule
